@@ rtl/hsl2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared constants and types of the hsl to rgb converter pipeline.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	localparam int FRACTION_BITS = 12;
	localparam int IBITS         = 16;
	localparam int UNIT_W        = IBITS + 1;
	localparam int T_W           = UNIT_W + 2;
	localparam int SLOPE_W       = 14;
	localparam int PROD_W        = UNIT_W + SLOPE_W;
	localparam int VAL_W         = UNIT_W + 1;

	localparam logic [UNIT_W-1:0] ONE_U        = UNIT_W'(1 << IBITS);
	localparam logic [UNIT_W-1:0] THIRD_U      = UNIT_W'(21845);
	localparam logic [UNIT_W-1:0] SIXTH_U      = UNIT_W'(10922);
	localparam logic [UNIT_W-1:0] HALF_U       = UNIT_W'(32768);
	localparam logic [UNIT_W-1:0] TWO_THIRDS_U = UNIT_W'(43690);

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	typedef struct packed {
		logic [UNIT_W-1:0] p;
		logic [UNIT_W-1:0] q;
		logic [UNIT_W-1:0] d;
	} ramp_pqd_t;

endpackage

@@ rtl/hsl2rgb_core.sv @@
// each item passes the registered stages s1 to s7 between input accept and output valid
// throughput: one item per cycle, the whole pipeline holds while an item waits at the output
// with m_axis_tready low
// the longest stage is one 17 x 17 multiply (lightness times saturation)
// reset clears all stage valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core
// HSL pixel to 8-bit RGB, fixed point, seven-stage stream pipeline.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_core
	import hsl2rgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // hue, saturation, lightness
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // red, green, blue
);

	localparam int SHIFT = IBITS - FRACTION_BITS;
	localparam logic signed [17:0] ONE_IN_S = 18'(1 << FRACTION_BITS);
	localparam logic signed [T_W-1:0] THIRD_S = T_W'(THIRD_U);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic [UNIT_W-1:0]   h_s1, s_s1, l_s1;
	logic [UNIT_W-1:0]   h_s2, s_s2, l_s2;
	logic [2*UNIT_W-1:0] ls_s2;

	logic [UNIT_W-1:0]        m_c;
	logic [T_W-1:0]           q_w;
	logic [UNIT_W-1:0]        q_c;
	logic signed [T_W-1:0]    p_w;
	logic [UNIT_W-1:0]        p_c;
	logic signed [T_W-1:0]    d_w;
	logic [UNIT_W-1:0]        d_c;
	logic signed [T_W-1:0]    hx_c;

	ramp_pqd_t         pqd_s3;
	logic [UNIT_W-1:0] tr_s3, tg_s3, tb_s3;
	logic [7:0]        red, green, blue;

	function automatic logic [UNIT_W-1:0] load_unit(input logic signed [15:0] raw);
		logic signed [16:0] v;
		logic [UNIT_W-1:0]  c;
		v = {raw[15], raw};
		if (v < 0) begin
			c = '0;
		end else if (v > ONE_IN_S) begin
			c = UNIT_W'(ONE_IN_S);
		end else begin
			c = UNIT_W'(v[15:0]);
		end
		return c << SHIFT;
	endfunction

	function automatic logic [UNIT_W-1:0] wrap_t(input logic signed [T_W-1:0] t);
		logic signed [T_W-1:0] r;
		if (t < 0) begin
			r = t + T_W'(ONE_U);
		end else if (t > T_W'(ONE_U)) begin
			r = t - T_W'(ONE_U);
		end else begin
			r = t;
		end
		return r[UNIT_W-1:0];
	endfunction

	assign en            = !vld_s7 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = {blue, green, red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// clamp to 0..1 and move to 16 fraction bits
	always_ff @(posedge clk) begin
		if (en) begin
			h_s1 <= load_unit(s_axis_tdata[15:0]);
			s_s1 <= load_unit(s_axis_tdata[31:16]);
			l_s1 <= load_unit(s_axis_tdata[47:32]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ls_s2 <= (2*UNIT_W)'(l_s1) * (2*UNIT_W)'(s_s1);
			h_s2  <= h_s1;
			s_s2  <= s_s1;
			l_s2  <= l_s1;
		end
	end

	// q, p and q - p, with p and q - p clamped at zero
	always_comb begin
		m_c = ls_s2[IBITS+UNIT_W-1:IBITS];
		if (l_s2 < HALF_U) begin
			q_w = T_W'(l_s2) + T_W'(m_c);
		end else begin
			q_w = T_W'(l_s2) + T_W'(s_s2) - T_W'(m_c);
		end
		q_c  = q_w[UNIT_W-1:0];
		p_w  = T_W'({l_s2, 1'b0}) - T_W'(q_c);
		p_c  = (p_w < 0) ? '0 : p_w[UNIT_W-1:0];
		d_w  = T_W'(q_c) - T_W'(p_c);
		d_c  = (d_w < 0) ? '0 : d_w[UNIT_W-1:0];
		hx_c = T_W'(h_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pqd_s3.p <= p_c;
			pqd_s3.q <= q_c;
			pqd_s3.d <= d_c;
			tr_s3    <= wrap_t(hx_c + THIRD_S);
			tg_s3    <= wrap_t(hx_c);
			tb_s3    <= wrap_t(hx_c - THIRD_S);
		end
	end

	hsl2rgb_chan u_red (
		.clk  (clk),
		.en   (en),
		.pqd  (pqd_s3),
		.t    (tr_s3),
		.chan (red)
	);

	hsl2rgb_chan u_green (
		.clk  (clk),
		.en   (en),
		.pqd  (pqd_s3),
		.t    (tg_s3),
		.chan (green)
	);

	hsl2rgb_chan u_blue (
		.clk  (clk),
		.en   (en),
		.pqd  (pqd_s3),
		.t    (tb_s3),
		.chan (blue)
	);

endmodule

@@ rtl/hsl2rgb_chan.sv @@
// ----------------------------------------------------------------------------
// hsl2rgb_chan
// One color channel: hue ramp at a wrapped position, scaled to 8 bits.
// Four register stages, advanced by a shared enable.
// ----------------------------------------------------------------------------
module hsl2rgb_chan
	import hsl2rgb_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  ramp_pqd_t         pqd,
	input  logic [UNIT_W-1:0] t,
	output logic [7:0]        chan
);

	localparam int SIX_W = PROD_W + 3;
	localparam int X_W   = VAL_W + 9;

	seg_t               seg_c;
	logic [SLOPE_W-1:0] u_c;

	seg_t               seg_s4;
	logic [SLOPE_W-1:0] u_s4;
	ramp_pqd_t          pqd_s4;

	seg_t               seg_s5;
	logic [PROD_W-1:0]  prod_s5;
	logic [UNIT_W-1:0]  p_s5;
	logic [UNIT_W-1:0]  q_s5;

	logic [SIX_W-1:0]   six_c;
	logic [VAL_W-1:0]   v_c;
	logic [VAL_W-1:0]   v_s6;

	logic [X_W-1:0]     x_c;
	logic [X_W-IBITS-1:0] r_c;

	// segment select and slope distance
	always_comb begin
		if (t < SIXTH_U) begin
			seg_c = SEG_RISE;
			u_c   = t[SLOPE_W-1:0];
		end else if (t < HALF_U) begin
			seg_c = SEG_HIGH;
			u_c   = '0;
		end else if (t < TWO_THIRDS_U) begin
			seg_c = SEG_FALL;
			u_c   = SLOPE_W'(TWO_THIRDS_U - t);
		end else begin
			seg_c = SEG_LOW;
			u_c   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s4 <= seg_c;
			u_s4   <= u_c;
			pqd_s4 <= pqd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s5  <= seg_s4;
			prod_s5 <= PROD_W'(pqd_s4.d) * PROD_W'(u_s4);
			p_s5    <= pqd_s4.p;
			q_s5    <= pqd_s4.q;
		end
	end

	// times six, truncated to 16 fraction bits
	always_comb begin
		six_c = SIX_W'({prod_s5, 2'b00}) + SIX_W'({prod_s5, 1'b0});
		case (seg_s5)
			SEG_RISE: v_c = VAL_W'(p_s5) + six_c[SIX_W-2:IBITS];
			SEG_FALL: v_c = VAL_W'(p_s5) + six_c[SIX_W-2:IBITS];
			SEG_HIGH: v_c = VAL_W'(q_s5);
			SEG_LOW:  v_c = VAL_W'(p_s5);
			default:  v_c = VAL_W'(p_s5);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s6 <= v_c;
		end
	end

	// scale by 255, round half up, saturate
	always_comb begin
		x_c = X_W'({v_s6, 8'b0}) - X_W'(v_s6) + X_W'(HALF_U);
		r_c = x_c[X_W-1:IBITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chan <= (r_c > (X_W-IBITS)'(255)) ? 8'hFF : r_c[7:0];
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the hsl to rgb pixel core: directed clamp, grey and hue
// segment edges, then random pixels under bursty input and a stalling
// output. Every item out is checked against a bit-true software predictor.
// ----------------------------------------------------------------------------
module testbench
	import hsl2rgb_pkg::*;
();

	localparam int       CLK_PERIOD  = 8;
	localparam int       CYCLE_LIMIT = 400000;
	localparam int       DRAIN_WAIT  = 24;
	localparam int       WIDE_BITS   = 16;
	localparam longint   UNIT_ONE    = 65536;
	localparam longint   UNIT_THIRD  = 21845;
	localparam longint   UNIT_SIXTH  = 10922;
	localparam longint   UNIT_HALF   = 32768;
	localparam longint   UNIT_2THIRD = 43690;
	localparam int       IN_ONE      = 1 << FRACTION_BITS;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // hue, saturation, lightness
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // red, green, blue

	rgb_t expected_rgb[$];
	int   mismatches;
	int   cycles;
	int   burst_left;

	hsl_to_rgb_converter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// clamp to 0..1.0 and move to 16 fraction bits
	function automatic longint unit_of(logic [15:0] raw);
		longint v;
		v = longint'($signed(raw));
		if (v < 0)
			v = 0;
		if (v > IN_ONE)
			v = IN_ONE;
		return v * (longint'(1) << (WIDE_BITS - FRACTION_BITS));
	endfunction

	function automatic longint ramp_level(longint p, longint q, longint t);
		longint d;
		d = q - p;
		if (d < 0)
			d = 0;
		if (t < 0)
			t = t + UNIT_ONE;
		else if (t > UNIT_ONE)
			t = t - UNIT_ONE;
		if (t < UNIT_SIXTH)
			return p + ((d * 6 * t) >>> WIDE_BITS);
		if (t < UNIT_HALF)
			return q;
		if (t < UNIT_2THIRD)
			return p + ((d * (UNIT_2THIRD - t) * 6) >>> WIDE_BITS);
		return p;
	endfunction

	function automatic logic [7:0] channel_byte(longint v);
		longint r;
		if (v < 0)
			v = 0;
		r = (v * 255 + UNIT_HALF) >>> WIDE_BITS;
		if (r > 255)
			r = 255;
		return r[7:0];
	endfunction

	function automatic rgb_t predict_rgb(logic [15:0] h_raw, logic [15:0] s_raw,
			logic [15:0] l_raw);
		longint h, s, l, q, p;
		rgb_t c;
		h = unit_of(h_raw);
		s = unit_of(s_raw);
		l = unit_of(l_raw);
		if (s == 0) begin
			c.red   = channel_byte(l);
			c.green = channel_byte(l);
			c.blue  = channel_byte(l);
		end else begin
			if (l < UNIT_HALF)
				q = (l * (UNIT_ONE + s)) >>> WIDE_BITS;
			else
				q = l + s - ((l * s) >>> WIDE_BITS);
			p = 2 * l - q;
			if (p < 0)
				p = 0;
			c.red   = channel_byte(ramp_level(p, q, h + UNIT_THIRD));
			c.green = channel_byte(ramp_level(p, q, h));
			c.blue  = channel_byte(ramp_level(p, q, h - UNIT_THIRD));
		end
		return c;
	endfunction

	// mostly in range, some near the clamp points, some raw 16-bit
	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 9))
			0, 1:    return 16'($urandom());
			2:       return 16'($urandom_range(0, 6));
			3:       return 16'(IN_ONE - 3 + $urandom_range(0, 6));
			4:       return 16'(-$urandom_range(1, 300));
			default: return 16'($urandom_range(0, IN_ONE));
		endcase
	endfunction

	task automatic send_pixel(logic [15:0] h, logic [15:0] s, logic [15:0] l);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {l, s, h};
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_rgb.insert(expected_rgb.size(), predict_rgb(h, s, l));
	endtask

	task automatic hold_sender(int n);
		repeat (n) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
	endtask

	task automatic send_paced(logic [15:0] h, logic [15:0] s, logic [15:0] l);
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0)
				hold_sender($urandom_range(1, 7));
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		send_pixel(h, s, l);
	endtask

	task automatic wait_for_drain();
		hold_sender(1);
		while (expected_rgb.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_clamp_extremes();
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'h7fff, 16'h7fff, 16'h7fff);
		send_pixel(16'h8000, 16'h8000, 16'h8000);
		send_pixel(16'hffff, 16'h7fff, 16'(IN_ONE / 2));
		send_pixel(16'(IN_ONE), 16'(IN_ONE), 16'(IN_ONE));
		send_pixel(16'(IN_ONE + 1), 16'(IN_ONE + 1), 16'(IN_ONE / 2 - 1));
		send_pixel(16'h5555, 16'haaaa, 16'(IN_ONE / 2));
		send_pixel(16'haaaa, 16'h5555, 16'(IN_ONE / 3));
	endtask

	task automatic test_grey();
		send_pixel(16'(IN_ONE / 5), 16'h0000, 16'(IN_ONE / 2));
		send_pixel(16'(IN_ONE / 2), 16'h8000, 16'(IN_ONE));
		send_pixel(16'h7fff, 16'hffff, 16'(IN_ONE / 7));
		send_pixel(16'h0000, 16'h0000, 16'h8000);
		send_pixel(16'h1234, 16'h0000, 16'(IN_ONE - 1));
	endtask

	// segment edges of the hue ramp, full and half saturation
	task automatic test_hue_segments();
		send_pixel(16'h0000, 16'(IN_ONE), 16'(IN_ONE / 2));
		send_pixel(16'(IN_ONE), 16'(IN_ONE), 16'(IN_ONE / 2));
		send_pixel(16'(IN_ONE / 6), 16'(IN_ONE), 16'(IN_ONE / 2));
		send_pixel(16'(IN_ONE / 6 + 1), 16'(IN_ONE), 16'(IN_ONE / 2));
		send_pixel(16'(IN_ONE / 3), 16'(IN_ONE / 2), 16'(IN_ONE / 4));
		send_pixel(16'(IN_ONE / 3 + 1), 16'(IN_ONE / 2), 16'(IN_ONE / 4));
		send_pixel(16'(IN_ONE / 2), 16'(IN_ONE), 16'(IN_ONE * 3 / 4));
		send_pixel(16'(IN_ONE * 2 / 3), 16'(IN_ONE), 16'(IN_ONE / 2));
		send_pixel(16'(IN_ONE * 2 / 3 + 1), 16'(IN_ONE / 2), 16'(IN_ONE / 2));
		send_pixel(16'(IN_ONE * 5 / 6), 16'(IN_ONE), 16'(IN_ONE / 2));
		hold_sender(1);
	endtask

	task automatic test_random_pixels(int n);
		repeat (n)
			send_paced(pick_field(), pick_field(), pick_field());
	endtask

	task automatic test_raw_fields(int n);
		repeat (n)
			send_paced(16'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	task automatic test_drain_pause();
		test_random_pixels(50);
		wait_for_drain();
		test_random_pixels(50);
	endtask

	// output side stall pattern, changes character every stretch
	initial begin : receiver
		int mode;
		int run;
		int phase;
		m_axis_tready = 1'b0;
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			run  = $urandom_range(16, 160);
			repeat (run) begin
				@(negedge clk);
				phase++;
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = 1'($urandom_range(0, 1));
					2: m_axis_tready = ($urandom_range(0, 7) != 0);
					default: m_axis_tready = ((phase % 12) < 4);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rgb.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item out: rgb %0d %0d %0d",
						m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]);
			end else begin
				rgb_t want;
				rgb_t got;
				want = expected_rgb.pop_front();
				got  = m_axis_tdata;
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected rgb %0d %0d %0d, got %0d %0d %0d",
							want.red, want.green, want.blue,
							got.red, got.green, got.blue);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		mismatches    = 0;
		cycles        = 0;
		burst_left    = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_clamp_extremes();
		test_grey();
		test_hue_segments();
		test_random_pixels(1200);
		test_drain_pause();
		test_raw_fields(400);

		wait_for_drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_rgb.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
